// ----- sv/mbd_pkg.sv -----
// Package for the multi-button debouncer.
// Holds widths, reset values, register indexes and the per-lane status type.
// No dependencies.
package mbd_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int FIELD_W      = 8;
  localparam int DELAY_W      = 16;
  localparam int EN_W         = 8;
  localparam int CNT_W        = 17;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd50;
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef struct packed {
    logic stable;
    logic prev;
    logic press;
    logic rel;
  } lane_t;

endpackage

// ----- sv/mbd_in_if.sv -----
// Input channel interface of the multi-button debouncer.
// Carries one sample tick per beat; depends on mbd_pkg.
interface mbd_in_if;
  logic                       valid;
  logic                       ready;
  logic [mbd_pkg::FIELD_W-1:0] raw_levels;
  logic [mbd_pkg::FIELD_W-1:0] clear_pressed;
  logic [mbd_pkg::FIELD_W-1:0] clear_released;

  modport source (output valid, raw_levels, clear_pressed, clear_released, input ready);
  modport sink   (input valid, raw_levels, clear_pressed, clear_released, output ready);
endinterface

// ----- sv/mbd_out_if.sv -----
// Result channel interface of the multi-button debouncer.
// Carries one status word set per beat; depends on mbd_pkg.
interface mbd_out_if;
  logic                       valid;
  logic                       ready;
  logic [mbd_pkg::FIELD_W-1:0] stable_levels;
  logic [mbd_pkg::FIELD_W-1:0] previous_raw;
  logic [mbd_pkg::FIELD_W-1:0] pressed_flags;
  logic [mbd_pkg::FIELD_W-1:0] released_flags;

  modport source (output valid, stable_levels, previous_raw, pressed_flags, released_flags,
                  input ready);
  modport sink   (input valid, stable_levels, previous_raw, pressed_flags, released_flags,
                  output ready);
endinterface

// ----- sv/mbd_cfg.sv -----
// APB-style configuration registers of the multi-button debouncer.
// Holds the shared debounce delay and the channel enable mask; depends on mbd_pkg.
module mbd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
  output logic [mbd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [mbd_pkg::DELAY_W-1:0] delay,
  output logic [mbd_pkg::EN_W-1:0]    enable
);

  logic [mbd_pkg::DELAY_W-1:0] delay_r;
  logic [mbd_pkg::EN_W-1:0]    enable_r;
  logic                        wr;
  logic                        sel;

  assign wr     = psel & penable & pwrite;
  assign sel    = paddr[mbd_pkg::ADDR_W-1];
  assign pready = 1'b1;
  assign delay  = delay_r;
  assign enable = enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= mbd_pkg::DELAY_RST;
      enable_r <= '0;
    end else if (wr) begin
      case (sel)
        mbd_pkg::REG_DELAY:  delay_r  <= pwdata[mbd_pkg::DELAY_W-1:0];
        mbd_pkg::REG_ENABLE: enable_r <= pwdata[mbd_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      mbd_pkg::REG_DELAY:
        prdata = {{(mbd_pkg::DATA_W-mbd_pkg::DELAY_W){1'b0}}, delay_r};
      mbd_pkg::REG_ENABLE:
        prdata = {{(mbd_pkg::DATA_W-mbd_pkg::EN_W){1'b0}}, enable_r};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- sv/mbd_lane.sv -----
// One debounce lane: change counter, stable level and latched edge flags.
// Updates its state on each tick step; depends on mbd_pkg.
module mbd_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        en,
  input  logic                        raw,
  input  logic                        clr_p,
  input  logic                        clr_r,
  input  logic [mbd_pkg::DELAY_W-1:0] delay,
  output mbd_pkg::lane_t              lane_nxt
);

  logic                      last_r, stable_r, press_r, rel_r;
  logic [mbd_pkg::CNT_W-1:0] cnt_r;
  logic [mbd_pkg::CNT_W-1:0] cnt_nxt;
  logic                      upd;

  always_comb begin
    if (raw != last_r) begin
      cnt_nxt = '0;
    end else if (cnt_r == mbd_pkg::CNT_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    upd = (cnt_nxt > {1'b0, delay}) && (stable_r != raw);
    if (en) begin
      lane_nxt.stable = upd ? raw : stable_r;
      lane_nxt.prev   = raw;
      lane_nxt.press  = (press_r & ~clr_p) | (upd & raw);
      lane_nxt.rel    = (rel_r & ~clr_r) | (upd & ~raw);
    end else begin
      lane_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      stable_r <= 1'b0;
      press_r  <= 1'b0;
      rel_r    <= 1'b0;
      cnt_r    <= '0;
    end else if (step) begin
      last_r   <= lane_nxt.prev;
      stable_r <= lane_nxt.stable;
      press_r  <= lane_nxt.press;
      rel_r    <= lane_nxt.rel;
      cnt_r    <= en ? cnt_nxt : '0;
    end
  end

endmodule

// ----- sv/multi_button_debouncer.sv -----
// Top level of the multi-button debouncer.
// Uses mbd_pkg, mbd_in_if, mbd_out_if, mbd_cfg and mbd_lane.
//
// Each input beat is one sample tick with the raw level of every button and
// two masks that clear latched press and release flags. Each tick yields
// exactly one result beat with stable levels, stored raw levels and the
// latched press and release flags after that tick.
// A beat is taken into an input register, processed by the lanes and written
// to the output register once that register is free. One beat is taken every
// cycle while the receiver does not stall; the lane update is a single pass of
// counter, compare and flag logic. When the receiver stalls, the result is
// held in the output register and one more input beat waits in the input
// register; then ready drops. Reset clears all lane state, sets the delay to
// 50 ticks and disables all channels. Registers are to be written through the
// APB-style port only while idle; the block itself does not enforce this.
module multi_button_debouncer #(
  parameter int CHANNELS = mbd_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mbd_in_if.sink                     in_ch,
  mbd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbd_pkg::ADDR_W-1:0] paddr,
  input  logic [mbd_pkg::DATA_W-1:0] pwdata,
  output logic [mbd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int FW = mbd_pkg::FIELD_W;

  logic [mbd_pkg::DELAY_W-1:0] delay;
  logic [mbd_pkg::EN_W-1:0]    enable;

  logic          in_valid_r;
  logic [FW-1:0] raw_r, clr_p_r, clr_r_r;
  logic          out_valid_r;
  logic [FW-1:0] stable_r, prev_r, press_r, rel_r;
  logic          adv;

  mbd_pkg::lane_t lane_nxt [CHANNELS];
  logic [FW-1:0]  stable_nxt, prev_nxt, press_nxt, rel_nxt;

  mbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delay   (delay),
    .enable  (enable)
  );

  assign adv         = in_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~in_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r   <= in_ch.raw_levels;
      clr_p_r <= in_ch.clear_pressed;
      clr_r_r <= in_ch.clear_released;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CHANNELS; i++) begin : g_lane
      logic en_i, raw_i, clr_p_i, clr_r_i;
      if (i < FW) begin : g_io
        assign raw_i   = raw_r[i];
        assign clr_p_i = clr_p_r[i];
        assign clr_r_i = clr_r_r[i];
      end else begin : g_noio
        assign raw_i   = 1'b0;
        assign clr_p_i = 1'b0;
        assign clr_r_i = 1'b0;
      end
      if (i < mbd_pkg::EN_W) begin : g_en
        assign en_i = enable[i];
      end else begin : g_noen
        assign en_i = 1'b0;
      end
      mbd_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (adv),
        .en       (en_i),
        .raw      (raw_i),
        .clr_p    (clr_p_i),
        .clr_r    (clr_r_i),
        .delay    (delay),
        .lane_nxt (lane_nxt[i])
      );
    end

    for (i = 0; i < FW; i++) begin : g_pack
      if (i < CHANNELS) begin : g_used
        assign stable_nxt[i] = lane_nxt[i].stable;
        assign prev_nxt[i]   = lane_nxt[i].prev;
        assign press_nxt[i]  = lane_nxt[i].press;
        assign rel_nxt[i]    = lane_nxt[i].rel;
      end else begin : g_pad
        assign stable_nxt[i] = 1'b0;
        assign prev_nxt[i]   = 1'b0;
        assign press_nxt[i]  = 1'b0;
        assign rel_nxt[i]    = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stable_r <= stable_nxt;
      prev_r   <= prev_nxt;
      press_r  <= press_nxt;
      rel_r    <= rel_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.stable_levels  = stable_r;
  assign out_ch.previous_raw   = prev_r;
  assign out_ch.pressed_flags  = press_r;
  assign out_ch.released_flags = rel_r;

endmodule

// ----- sv/mbd_checker.sv -----
// Port-level checker for the multi-button debouncer, bound to the top level.
// Depends on mbd_pkg and on the top level's ports.
module mbd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [4*mbd_pkg::FIELD_W-1:0] out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat present right after reset.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result beat appeared without an input beat two cycles earlier.");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("Input stalled while the result side was free.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Result valid dropped before the beat was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.stable_levels, out_ch.previous_raw,
               out_ch.pressed_flags, out_ch.released_flags})
);

// ----- sim/tb.sv -----
// Testbench for multi_button_debouncer: directed and random sample ticks are
// checked beat by beat against a behavioral debounce predictor in this file.
// Depends on mbd_pkg, mbd_in_if, mbd_out_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W      = mbd_pkg::FIELD_W;
  localparam int ADDR_W       = mbd_pkg::ADDR_W;
  localparam int DATA_W       = mbd_pkg::DATA_W;
  localparam int DELAY_W      = mbd_pkg::DELAY_W;
  localparam int EN_W         = mbd_pkg::EN_W;
  localparam int CNT_W        = mbd_pkg::CNT_W;
  localparam int CHANNELS_DEF = mbd_pkg::CHANNELS_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] stable;
    logic [FIELD_W-1:0] prev;
    logic [FIELD_W-1:0] press;
    logic [FIELD_W-1:0] rel;
  } status_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mbd_in_if  in_bus ();
  mbd_out_if out_bus ();

  multi_button_debouncer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [DELAY_W-1:0]      pred_delay;
  logic [EN_W-1:0]         pred_enable;
  logic [CHANNELS_DEF-1:0] pred_last;
  logic [CHANNELS_DEF-1:0] pred_stable;
  logic [CHANNELS_DEF-1:0] pred_press;
  logic [CHANNELS_DEF-1:0] pred_rel;
  logic [CNT_W-1:0]        pred_ticks [CHANNELS_DEF];

  status_t pending_status[$];
  int      errors;
  bit      idle_on;
  int      hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic logic [FIELD_W-1:0] draw_clear();
    return ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 255)) : '0;
  endfunction

  function automatic void reset_debouncer_state();
    pred_delay  = mbd_pkg::DELAY_RST;
    pred_enable = '0;
    pred_last   = '0;
    pred_stable = '0;
    pred_press  = '0;
    pred_rel    = '0;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      pred_ticks[i] = '0;
    end
  endfunction

  function automatic status_t debounce_tick(input logic [FIELD_W-1:0] raw,
                                            input logic [FIELD_W-1:0] clr_press,
                                            input logic [FIELD_W-1:0] clr_rel);
    status_t s;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      if (!pred_enable[i]) begin
        pred_last[i]   = 1'b0;
        pred_stable[i] = 1'b0;
        pred_press[i]  = 1'b0;
        pred_rel[i]    = 1'b0;
        pred_ticks[i]  = '0;
      end else begin
        if (clr_press[i]) pred_press[i] = 1'b0;
        if (clr_rel[i]) pred_rel[i] = 1'b0;
        if (raw[i] != pred_last[i]) begin
          pred_ticks[i] = '0;
        end else if (pred_ticks[i] != mbd_pkg::CNT_MAX) begin
          pred_ticks[i] = pred_ticks[i] + 1'b1;
        end
        if (pred_ticks[i] > CNT_W'(pred_delay) && pred_stable[i] != raw[i]) begin
          pred_stable[i] = raw[i];
          if (raw[i]) pred_press[i] = 1'b1;
          else pred_rel[i] = 1'b1;
        end
        pred_last[i] = raw[i];
      end
    end
    s.stable = pred_stable;
    s.prev   = pred_last;
    s.press  = pred_press;
    s.rel    = pred_rel;
    return s;
  endfunction

  task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == mbd_pkg::REG_DELAY) pred_delay = value[DELAY_W-1:0];
    else pred_enable = value[EN_W-1:0];
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic idx);
    logic [DATA_W-1:0] want;
    want = (idx == mbd_pkg::REG_DELAY) ? DATA_W'(pred_delay) : DATA_W'(pred_enable);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((idx == mbd_pkg::REG_DELAY && prdata[DELAY_W-1:0] !== want[DELAY_W-1:0]) ||
        (idx == mbd_pkg::REG_ENABLE && prdata[EN_W-1:0] !== want[EN_W-1:0])) begin
      note_error($sformatf("register %0d read: expected %h, got %h", idx, want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Leaves valid high so that a back-to-back beat keeps it up.
  task automatic send_tick(input logic [FIELD_W-1:0] raw,
                           input logic [FIELD_W-1:0] clr_press,
                           input logic [FIELD_W-1:0] clr_rel);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.raw_levels     <= raw;
    in_bus.clear_pressed  <= clr_press;
    in_bus.clear_released <= clr_rel;
    do @(posedge clk); while (!in_bus.ready);
    pending_status.push_back(debounce_tick(raw, clr_press, clr_rel));
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    while (pending_status.size() > 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic random_ticks(input int n, input int span);
    logic [FIELD_W-1:0] cur;
    logic [FIELD_W-1:0] m;
    int run;
    int sel;
    int sent;
    cur  = FIELD_W'($urandom_range(0, 255));
    sent = 0;
    while (sent < n) begin
      run = $urandom_range(0, span + 4);
      repeat (run) begin
        send_tick(cur, draw_clear(), draw_clear());
        sent++;
      end
      m   = FIELD_W'($urandom_range(1, 255));
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
        cur = cur ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
      end else if (sel <= 6) begin
        cur = cur ^ m;
      end else if (sel <= 8) begin
        send_tick(cur ^ m, draw_clear(), draw_clear());
        sent++;
      end else begin
        cur = FIELD_W'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 14) == 0) idle_on = !idle_on;
    end
  endtask

  task automatic test_reset_values();
    cfg_check(mbd_pkg::REG_DELAY);
    cfg_check(mbd_pkg::REG_ENABLE);
    repeat (3) send_tick(8'hFF, 8'hFF, 8'hFF);
    wait_drain();
  endtask

  task automatic test_directed();
    logic [3*FIELD_W-1:0] seq_zero [16] = '{
      24'hFF0000, 24'hFF0000, 24'hFFFF00, 24'h000000,
      24'h000000, 24'h0000FF, 24'hAA0000, 24'h550000,
      24'hAA0000, 24'h550000, 24'h550000, 24'h5555FF,
      24'h0F0000, 24'h0FFF00, 24'hF000FF, 24'hF000FF
    };
    logic [3*FIELD_W-1:0] seq_masked [8] = '{
      24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000,
      24'h00FF00, 24'h000000, 24'h000000, 24'h0000FF
    };
    cfg_write(mbd_pkg::REG_DELAY, '0);
    cfg_write(mbd_pkg::REG_ENABLE, 32'hFF);
    foreach (seq_zero[i]) begin
      send_tick(seq_zero[i][23:16], seq_zero[i][15:8], seq_zero[i][7:0]);
    end
    wait_drain();
    cfg_write(mbd_pkg::REG_DELAY, 32'd2);
    cfg_write(mbd_pkg::REG_ENABLE, 32'hA5);
    cfg_check(mbd_pkg::REG_DELAY);
    cfg_check(mbd_pkg::REG_ENABLE);
    foreach (seq_masked[i]) begin
      send_tick(seq_masked[i][23:16], seq_masked[i][15:8], seq_masked[i][7:0]);
    end
    wait_drain();
  endtask

  task automatic test_longest_delay();
    idle_on = 1'b0;
    cfg_write(mbd_pkg::REG_DELAY, 32'hFFFF);
    cfg_write(mbd_pkg::REG_ENABLE, 32'hFF);
    cfg_check(mbd_pkg::REG_DELAY);
    repeat (40) send_tick(8'hFF, 8'h00, 8'h00);
    repeat (4) send_tick(8'h00, 8'hFF, 8'h00);
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [DELAY_W-1:0] d;
    logic [EN_W-1:0]    en;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin d = '0; en = 8'hFF; end
        1: begin d = 16'd1; en = EN_W'($urandom_range(0, 255)); end
        2: begin d = 16'd3; en = 8'hFF; end
        3: begin d = DELAY_W'($urandom_range(0, 6)); en = EN_W'($urandom_range(0, 255)); end
        4: begin d = 16'hFFFF; en = EN_W'($urandom_range(0, 255)); end
        default: begin d = DELAY_W'($urandom_range(0, 8)); en = 8'hFF; end
      endcase
      cfg_write(mbd_pkg::REG_DELAY, DATA_W'(d));
      cfg_write(mbd_pkg::REG_ENABLE, DATA_W'(en));
      random_ticks(200, (d > 8) ? 8 : int'(d));
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    cfg_write(mbd_pkg::REG_DELAY, 32'd1);
    cfg_write(mbd_pkg::REG_ENABLE, 32'hFF);
    hold_cycles = 80;
    random_ticks(40, 1);
    wait_drain();
    idle_on = 1'b1;
    random_ticks(20, 1);
    wait_drain();
  endtask

  // Result-side ready: a random stall per beat, plus long hold-offs on request.
  initial begin
    int rx_wait;
    rx_wait = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        rx_wait = draw_wait();
        out_bus.ready <= (rx_wait == 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_bus.ready <= (rx_wait == 0);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = {out_bus.stable_levels, out_bus.previous_raw,
             out_bus.pressed_flags, out_bus.released_flags};
      if (pending_status.size() == 0) begin
        note_error($sformatf("unexpected result beat %h", got));
      end else begin
        want = pending_status.pop_front();
        if (got.stable !== want.stable || got.prev !== want.prev ||
            got.press !== want.press || got.rel !== want.rel) begin
          note_error($sformatf(
            "mismatch: stable %h/%h prev %h/%h press %h/%h rel %h/%h (expected/actual)",
            want.stable, got.stable, want.prev, got.prev,
            want.press, got.press, want.rel, got.rel));
        end
      end
    end
  end

  initial begin
    errors      = 0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_bus.valid          <= 1'b0;
    in_bus.raw_levels     <= '0;
    in_bus.clear_pressed  <= '0;
    in_bus.clear_released <= '0;
    reset_debouncer_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_longest_delay();
    test_random();
    test_backpressure();

    wait_drain();
    repeat (10) @(posedge clk);
    if (pending_status.size() > 0) begin
      note_error($sformatf("%0d expected results never arrived", pending_status.size()));
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mbd_pkg.sv
sv/mbd_in_if.sv
sv/mbd_out_if.sv
sv/mbd_cfg.sv
sv/mbd_lane.sv
sv/multi_button_debouncer.sv
sv/mbd_checker.sv
sim/tb.sv
